// File: rtl/core/tvd_pkg.sv
// ---------------------------------------------------------------------------
// tvd_pkg: shared types and constants of the tagged varint stream decoder
// Holds the phase, type and status codes, the tag characters and the
// operation word that travels from the front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package tvd_pkg;

  // operation queue geometry
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // tag characters
  localparam logic [7:0] TagTrue  = 8'h74;  // 't'
  localparam logic [7:0] TagFalse = 8'h66;  // 'f'
  localparam logic [7:0] TagShort = 8'h73;  // 's'
  localparam logic [7:0] TagInt   = 8'h69;  // 'i'
  localparam logic [7:0] TagLong  = 8'h6C;  // 'l'
  localparam logic [7:0] TagChar  = 8'h63;  // 'c'
  localparam logic [7:0] TagStr   = 8'h53;  // 'S'

  // header nibble limits
  localparam logic [3:0] HdrMaxBytes = 4'd8;
  localparam logic [5:0] TopBitPos   = 6'd63;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR   = 3'd1,
    PH_BYTES = 3'd2,
    PH_CHAR  = 3'd3,
    PH_STR   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    TY_BOOL  = 3'd0,
    TY_SHORT = 3'd1,
    TY_INT   = 3'd2,
    TY_LONG  = 3'd3,
    TY_CHAR  = 3'd4,
    TY_STR   = 3'd5
  } type_e;

  typedef enum logic [2:0] {
    ST_VALUE = 3'd0,
    ST_SCHAR = 3'd1,
    ST_EMPTY = 3'd2,
    ST_TAG   = 3'd3,
    ST_BIG   = 3'd4,
    ST_RANGE = 3'd5,
    ST_TRUNC = 3'd6
  } status_e;

  // emit: deliver data as is; finish_int: sign-extend and range check
  typedef enum logic {
    OP_EMIT = 1'b0,
    OP_INT  = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] data;
    logic [5:0]  pos;
    logic [2:0]  ty;
    status_e     status;
    logic        last;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/tvd_if.sv
// ---------------------------------------------------------------------------
// tvd_if: stream channels of the tagged varint stream decoder
// Input channel carries one stream byte a word, output channel one result.
// ---------------------------------------------------------------------------
`default_nettype none

interface tvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [2:0] func;
  logic       stream_end;

  modport source (output valid, data_byte, func, stream_end, input ready);
  modport sink   (input valid, data_byte, func, stream_end, output ready);
endinterface

interface tvd_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, value, status, last, input ready);
  modport sink   (input valid, value, status, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tvd_front.sv
// ---------------------------------------------------------------------------
// tvd_front: byte classifier and item sequencer
// Tracks the item in progress, gathers integer bytes and string lengths,
// and pushes one operation word per result into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tvd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tvd_in_if.sink             in_i,
  input  wire logic          q_full_i,
  output tvd_pkg::push_t     push_o
);

  tvd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      exp_type_q, exp_type_d;
  logic [3:0]      bytes_left_q, bytes_left_d;
  logic [63:0]     acc_q, acc_d;
  logic [5:0]      pos_q, pos_d;
  logic [63:0]     chars_q, chars_d;

  logic        accept;
  logic [3:0]  hdr_n;
  logic [63:0] hdr_acc;
  logic [5:0]  hdr_pos;
  logic [63:0] byte_acc;
  logic [63:0] fin_acc;
  logic [5:0]  fin_pos;
  logic        fin_sign;
  logic        fin_zero;
  logic [3:0]  bytes_dec;
  logic [63:0] chars_dec;

  // take a word whenever the queue has room
  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // header and data byte decode
  assign hdr_n    = in_i.data_byte[7:4];
  assign hdr_acc  = (hdr_n == tvd_pkg::HdrMaxBytes) ? 64'd0 : {60'd0, in_i.data_byte[3:0]};
  assign hdr_pos  = (hdr_n == tvd_pkg::HdrMaxBytes) ? tvd_pkg::TopBitPos
                                                    : {hdr_n[2:0], 3'b011};
  assign byte_acc = {acc_q[55:0], in_i.data_byte};
  assign fin_acc  = (phase_q == tvd_pkg::PH_HDR) ? hdr_acc : byte_acc;
  assign fin_pos  = (phase_q == tvd_pkg::PH_HDR) ? hdr_pos : pos_q;
  assign fin_sign = fin_acc[fin_pos];
  assign fin_zero = (fin_acc == 64'd0);
  assign bytes_dec = bytes_left_q - 4'd1;
  assign chars_dec = chars_q - 64'd1;

  // next state and queue push
  always_comb begin
    phase_d      = phase_q;
    exp_type_d   = exp_type_q;
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    pos_d        = pos_q;
    chars_d      = chars_q;
    push_o.valid     = 1'b0;
    push_o.op.op     = tvd_pkg::OP_EMIT;
    push_o.op.data   = 64'd0;
    push_o.op.pos    = fin_pos;
    push_o.op.ty     = exp_type_q;
    push_o.op.status = tvd_pkg::ST_VALUE;
    push_o.op.last   = 1'b1;

    if (accept) begin
      if (in_i.stream_end) begin
        if (phase_q != tvd_pkg::PH_IDLE) begin
          phase_d          = tvd_pkg::PH_IDLE;
          push_o.valid     = 1'b1;
          push_o.op.status = tvd_pkg::ST_TRUNC;
        end
      end else begin
        unique case (phase_q)
          tvd_pkg::PH_IDLE: begin
            exp_type_d = in_i.func;
            // wrong tag unless a match below clears it
            push_o.valid     = 1'b1;
            push_o.op.status = tvd_pkg::ST_TAG;
            push_o.op.data   = {56'd0, in_i.data_byte};
            case (in_i.func)
              tvd_pkg::TY_BOOL: begin
                if (in_i.data_byte == tvd_pkg::TagTrue) begin
                  push_o.op.status = tvd_pkg::ST_VALUE;
                  push_o.op.data   = 64'd1;
                end else if (in_i.data_byte == tvd_pkg::TagFalse) begin
                  push_o.op.status = tvd_pkg::ST_VALUE;
                  push_o.op.data   = 64'd0;
                end
              end
              tvd_pkg::TY_SHORT: begin
                if (in_i.data_byte == tvd_pkg::TagShort) begin
                  push_o.valid = 1'b0;
                  phase_d      = tvd_pkg::PH_HDR;
                end
              end
              tvd_pkg::TY_INT: begin
                if (in_i.data_byte == tvd_pkg::TagInt) begin
                  push_o.valid = 1'b0;
                  phase_d      = tvd_pkg::PH_HDR;
                end
              end
              tvd_pkg::TY_LONG: begin
                if (in_i.data_byte == tvd_pkg::TagLong) begin
                  push_o.valid = 1'b0;
                  phase_d      = tvd_pkg::PH_HDR;
                end
              end
              tvd_pkg::TY_CHAR: begin
                if (in_i.data_byte == tvd_pkg::TagChar) begin
                  push_o.valid = 1'b0;
                  phase_d      = tvd_pkg::PH_CHAR;
                end
              end
              tvd_pkg::TY_STR: begin
                if (in_i.data_byte == tvd_pkg::TagStr) begin
                  push_o.valid = 1'b0;
                  phase_d      = tvd_pkg::PH_HDR;
                end
              end
              default: ;
            endcase
          end

          tvd_pkg::PH_HDR, tvd_pkg::PH_BYTES: begin
            if ((phase_q == tvd_pkg::PH_HDR) && (hdr_n > tvd_pkg::HdrMaxBytes)) begin
              phase_d          = tvd_pkg::PH_IDLE;
              push_o.valid     = 1'b1;
              push_o.op.status = tvd_pkg::ST_BIG;
            end else if ((phase_q == tvd_pkg::PH_HDR && hdr_n != 4'd0) ||
                         (phase_q == tvd_pkg::PH_BYTES && bytes_dec != 4'd0)) begin
              // more extra bytes to come
              acc_d        = fin_acc;
              pos_d        = fin_pos;
              bytes_left_d = (phase_q == tvd_pkg::PH_HDR) ? hdr_n : bytes_dec;
              phase_d      = tvd_pkg::PH_BYTES;
            end else begin
              // integer complete
              acc_d        = fin_acc;
              pos_d        = fin_pos;
              bytes_left_d = 4'd0;
              phase_d      = tvd_pkg::PH_IDLE;
              if (exp_type_q == tvd_pkg::TY_STR) begin
                if (fin_sign || fin_zero) begin
                  push_o.valid     = 1'b1;
                  push_o.op.status = tvd_pkg::ST_EMPTY;
                end else begin
                  chars_d = fin_acc;
                  phase_d = tvd_pkg::PH_STR;
                end
              end else begin
                push_o.valid   = 1'b1;
                push_o.op.op   = tvd_pkg::OP_INT;
                push_o.op.data = fin_acc;
              end
            end
          end

          tvd_pkg::PH_CHAR: begin
            phase_d        = tvd_pkg::PH_IDLE;
            push_o.valid   = 1'b1;
            push_o.op.data = {56'd0, in_i.data_byte};
          end

          tvd_pkg::PH_STR: begin
            chars_d          = chars_dec;
            push_o.valid     = 1'b1;
            push_o.op.status = tvd_pkg::ST_SCHAR;
            push_o.op.data   = {56'd0, in_i.data_byte};
            push_o.op.last   = (chars_dec == 64'd0);
            if (chars_dec == 64'd0) begin
              phase_d = tvd_pkg::PH_IDLE;
            end
          end

          default: begin
            phase_d = tvd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tvd_pkg::PH_IDLE;
      exp_type_q   <= 3'd0;
      bytes_left_q <= 4'd0;
      acc_q        <= 64'd0;
      pos_q        <= 6'd0;
      chars_q      <= 64'd0;
    end else begin
      phase_q      <= phase_d;
      exp_type_q   <= exp_type_d;
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      pos_q        <= pos_d;
      chars_q      <= chars_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tvd_queue.sv
// ---------------------------------------------------------------------------
// tvd_queue: operation queue between front end and back end
// Small register FIFO that lets either side stall without the other.
// ---------------------------------------------------------------------------
`default_nettype none

module tvd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tvd_pkg::push_t push_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      tvd_pkg::op_t   head_o,
  output      logic           avail_o
);

  tvd_pkg::op_t                ent_q [tvd_pkg::QDepth];
  logic [tvd_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tvd_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tvd_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                        do_push;
  logic                        do_pop;

  assign full_o  = (cnt_q == tvd_pkg::QCntW'(tvd_pkg::QDepth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && avail_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tvd_pkg::QPtrW'(tvd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tvd_pkg::QPtrW'(tvd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_i.op;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("operation pushed into a full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tvd_pkg::QCntW'(tvd_pkg::QDepth))
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: rtl/core/tvd_back.sv
// ---------------------------------------------------------------------------
// tvd_back: result formatter and output register
// Sign-extends finished integers, range checks short and int, and holds
// the result word until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module tvd_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire tvd_pkg::op_t head_i,
  input  wire logic         avail_i,
  output      logic         pop_o,
  tvd_out_if.source         out_o
);

  logic               valid_q, valid_d;
  logic signed [63:0] value_q;
  tvd_pkg::status_e   status_q;
  logic               last_q;

  logic [63:0]      ext_mask;
  logic [63:0]      ext_val;
  logic             short_ok;
  logic             int_ok;
  logic [63:0]      res_value;
  tvd_pkg::status_e res_status;

  // load a new word when the register is free or being drained
  assign pop_o   = avail_i && (!valid_q || out_o.ready);
  assign valid_d = pop_o ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  // sign extension from the header-given bit
  assign ext_mask = ~64'd0 << head_i.pos;
  assign ext_val  = head_i.data[head_i.pos] ? (head_i.data | ext_mask) : head_i.data;
  assign short_ok = (&ext_val[63:15]) || !(|ext_val[63:15]);
  assign int_ok   = (&ext_val[63:31]) || !(|ext_val[63:31]);

  // result selection
  always_comb begin
    res_value  = head_i.data;
    res_status = head_i.status;
    if (head_i.op == tvd_pkg::OP_INT) begin
      res_value  = ext_val;
      res_status = tvd_pkg::ST_VALUE;
      if (((head_i.ty == tvd_pkg::TY_SHORT) && !short_ok) ||
          ((head_i.ty == tvd_pkg::TY_INT) && !int_ok)) begin
        res_value  = 64'd0;
        res_status = tvd_pkg::ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q  <= res_value;
      status_q <= res_status;
      last_q   <= head_i.last;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;
  assign out_o.last   = last_q;

endmodule

`default_nettype wire

// File: rtl/core/tagged_varint_stream_decoder.sv
// ---------------------------------------------------------------------------
// tagged_varint_stream_decoder: typed byte stream decoder
// Usage:
//   in_i carries one word per stream byte: data_byte, the expected type
//   func (read on tag bytes only) and stream_end, which marks the end of
//   the stream and carries no byte. out_o carries one result word: the
//   64-bit value, a status code and last on the final word of an item.
//   A word is taken at a clock edge where valid and ready are both high.
//   Bytes are taken one per cycle while ready is high. A byte that yields a
//   result passes the queue and output register to out_o; bytes inside an
//   item (headers, length bytes, extra integer bytes) yield nothing. The
//   front end feeds a two-word operation queue; the back end sign-extends
//   and range checks integers into the output register. A stall on out_o
//   fills the queue, then in_i.ready drops until the receiver takes a word.
//   Reset (rst_ni low, asynchronous) empties queue and output register and
//   returns the decoder to waiting for a tag byte.
// ---------------------------------------------------------------------------
`default_nettype none

module tagged_varint_stream_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tvd_in_if.sink     in_i,
  tvd_out_if.source  out_o
);

  tvd_pkg::push_t push;
  tvd_pkg::op_t   head;
  logic           q_full;
  logic           q_avail;
  logic           q_pop;

  // classify bytes and sequence items
  tvd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  // decouple front and back
  tvd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head),
    .avail_o (q_avail)
  );

  // format and deliver results
  tvd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .avail_i (q_avail),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
